@@ hw/rtl/pcg_pkg.sv @@
// shared types and constants of the pcg32 bounded generator
package pcg_pkg;

    localparam logic [63:0] PCG_MULT     = 64'h5851_F42D_4C95_7F2D;
    localparam logic [31:0] PCG_MULT_LO  = PCG_MULT[31:0];
    localparam logic [31:0] PCG_MULT_HI  = PCG_MULT[63:32];
    localparam logic [62:0] STREAM_RESET = 63'h1FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_DRAW32  = 2'd0,
        ACT_DRAW64  = 2'd1,
        ACT_BOUNDED = 2'd2,
        ACT_RESEED  = 2'd3
    } pcg_action_t;

    localparam logic REG_SEED   = 1'b0;
    localparam logic REG_STREAM = 1'b1;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } pcg_mod_rsp_t;

    // xsh-rr output permutation of the pre-step state
    function automatic logic [31:0] pcg_output(input logic [63:0] old);
        logic [63:0] mixed;
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        mixed = (old >> 18) ^ old;
        xs    = mixed[58:27];
        rot   = old[63:59];
        dbl   = {xs, xs} >> rot;
        return dbl[31:0];
    endfunction

endpackage

@@ hw/rtl/pcg32_bounded_random_generator.sv @@
// pcg32 generator with xsh-rr output, bounded draws and reseed, top level
// One request is taken at a time; s_ready is high only while the sequencer is idle, and a
// finished result waits in the output register while the next request is taken. Every
// 64-bit state step runs three passes through one shared 32x32 multiplier plus an add.
// Each rejected bounded draw takes a fresh state step, and the first rejection candidate of
// a request has its threshold worked out by the bit-serial remainder unit, one bit per cycle.
// Registers: seed at byte address 0x0 (64 bits), stream at 0x8 (63 bits); reseed takes
// effect only through a reseed request.
module pcg32_bounded_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_range,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic [31:0] m_draw_count
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_UPD,
        S_SEED,
        S_LMUL,
        S_LCAP,
        S_CHK,
        S_DIV,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic [63:0] seed_reg;
    logic [62:0] stream_reg;
    logic [63:0] lcg_reg;
    logic [63:0] inc_reg;
    logic [31:0] cnt_reg;
    logic [1:0]  action_reg;
    logic [31:0] range_reg;
    logic        phase_reg;
    logic [31:0] x_reg;
    logic [31:0] hi_reg;
    logic [63:0] acc_reg;
    logic [63:0] m_reg;
    logic [31:0] t_reg;
    logic        t_valid_reg;
    logic [63:0] result_reg;
    logic        m_valid_reg;
    logic [63:0] m_value_reg;
    logic [31:0] m_count_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic        div_start;
    logic        cfg_write;
    logic        out_free;
    logic        accept_ok;

    pcg_pkg::pcg_mod_rsp_t div_rsp;

    pcg_mul32 u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    pcg_mod32 u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (32'd0 - range_reg),
        .divisor  (range_reg),
        .rsp      (div_rsp)
    );

    always_comb begin
        mul_a = lcg_reg[31:0];
        mul_b = pcg_pkg::PCG_MULT_LO;
        case (state_reg)
            S_M1: begin
                mul_a = lcg_reg[31:0];
                mul_b = pcg_pkg::PCG_MULT_HI;
            end
            S_M2: begin
                mul_a = lcg_reg[63:32];
                mul_b = pcg_pkg::PCG_MULT_LO;
            end
            S_LMUL: begin
                mul_a = x_reg;
                mul_b = range_reg;
            end
            default: begin
                mul_a = lcg_reg[31:0];
                mul_b = pcg_pkg::PCG_MULT_LO;
            end
        endcase
    end

    // accept when the low product word clears range, or clears the threshold once known
    assign accept_ok = (m_reg[31:0] >= range_reg) || (t_valid_reg && (m_reg[31:0] >= t_reg));
    assign div_start = (state_reg == S_CHK) && !accept_ok && !t_valid_reg;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            seed_reg    <= '0;
            stream_reg  <= pcg_pkg::STREAM_RESET;
            lcg_reg     <= '0;
            inc_reg     <= 64'd1;
            cnt_reg     <= '0;
            phase_reg   <= 1'b0;
            t_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                if (paddr[3] == pcg_pkg::REG_STREAM) begin
                    stream_reg <= pwdata[62:0];
                end else begin
                    seed_reg <= pwdata;
                end
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        action_reg  <= s_action;
                        range_reg   <= s_range;
                        phase_reg   <= 1'b0;
                        t_valid_reg <= 1'b0;
                        if (s_action == pcg_pkg::ACT_RESEED) begin
                            inc_reg <= {stream_reg, 1'b1};
                            lcg_reg <= '0;
                        end
                        state_reg <= S_M0;
                    end
                end
                S_M0: begin
                    x_reg     <= pcg_pkg::pcg_output(lcg_reg);
                    state_reg <= S_M1;
                end
                S_M1: begin
                    acc_reg   <= mul_p;
                    state_reg <= S_M2;
                end
                S_M2: begin
                    acc_reg[63:32] <= acc_reg[63:32] + mul_p[31:0];
                    state_reg      <= S_M3;
                end
                S_M3: begin
                    acc_reg[63:32] <= acc_reg[63:32] + mul_p[31:0];
                    state_reg      <= S_UPD;
                end
                S_UPD: begin
                    lcg_reg <= acc_reg + {inc_reg[63:1], 1'b1};
                    // second reseed step clears the counter
                    cnt_reg <= (action_reg == pcg_pkg::ACT_RESEED && phase_reg) ?
                               32'd0 : cnt_reg + 32'd1;
                    case (action_reg)
                        pcg_pkg::ACT_DRAW32: begin
                            result_reg <= {32'd0, x_reg};
                            state_reg  <= S_DONE;
                        end
                        pcg_pkg::ACT_DRAW64: begin
                            if (!phase_reg) begin
                                hi_reg    <= x_reg;
                                phase_reg <= 1'b1;
                                state_reg <= S_M0;
                            end else begin
                                result_reg <= {hi_reg, x_reg};
                                state_reg  <= S_DONE;
                            end
                        end
                        pcg_pkg::ACT_BOUNDED: begin
                            state_reg <= S_LMUL;
                        end
                        default: begin
                            if (!phase_reg) begin
                                phase_reg <= 1'b1;
                                state_reg <= S_SEED;
                            end else begin
                                result_reg <= '0;
                                state_reg  <= S_DONE;
                            end
                        end
                    endcase
                end
                S_SEED: begin
                    lcg_reg   <= lcg_reg + seed_reg;
                    state_reg <= S_M0;
                end
                S_LMUL: begin
                    state_reg <= S_LCAP;
                end
                S_LCAP: begin
                    m_reg     <= mul_p;
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    if (accept_ok) begin
                        result_reg <= {32'd0, m_reg[63:32]};
                        state_reg  <= S_DONE;
                    end else if (t_valid_reg) begin
                        state_reg <= S_M0;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        t_reg       <= div_rsp.rem;
                        t_valid_reg <= 1'b1;
                        state_reg   <= S_CHK;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_value_reg <= result_reg;
                        m_count_reg <= cnt_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_draw_count = m_count_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[3] == pcg_pkg::REG_STREAM) ? {1'b0, stream_reg} : seed_reg;

`ifndef NO_ASSERTIONS
    a_inc_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        inc_reg[0] == 1'b1)
        else $error("lcg increment lost its low bit");

    a_reseed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && action_reg == pcg_pkg::ACT_RESEED && out_free)
        |=> (m_value == 64'd0 && m_draw_count == 32'd0))
        else $error("reseed transfer carries nonzero value or count");

    a_thresh_below_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK && t_valid_reg) |-> (t_reg < range_reg))
        else $error("rejection threshold not below range");

    a_div_only_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (action_reg == pcg_pkg::ACT_BOUNDED && range_reg != 32'd0))
        else $error("remainder unit started outside a bounded draw");
`endif

endmodule

@@ hw/rtl/pcg_mul32.sv @@
// shared 32x32 multiplier with registered product
module pcg_mul32 (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= {32'd0, a} * {32'd0, b};
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/pcg_mod32.sv @@
// bit-serial 32-bit remainder unit, one quotient bit per cycle
module pcg_mod32 (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [31:0]           dividend,
    input  logic [31:0]           divisor,
    output pcg_pkg::pcg_mod_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {rem_reg, dvd_reg[31]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                if (trial >= {1'b0, dsr_reg}) begin
                    rem_reg <= diff[31:0];
                end else begin
                    rem_reg <= trial[31:0];
                end
                dvd_reg <= {dvd_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule
